// ===== src/clk_cal_pkg.sv =====
// ----------------------------------------------------------------------------
// clk_cal_pkg
// Types, constants and the month length table shared by the clock and
// calendar counter.
// ----------------------------------------------------------------------------
package clk_cal_pkg;

  localparam int unsigned TICK_W  = 16;
  localparam int unsigned SEC_W   = 6;
  localparam int unsigned MIN_W   = 6;
  localparam int unsigned HOUR_W  = 5;
  localparam int unsigned FMT_W   = 2;
  localparam int unsigned WDAY_W  = 3;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;

  localparam logic [TICK_W-1:0]  TICKS_RESET     = 16'd1000;
  localparam logic [SEC_W-1:0]   LAST_SECOND     = 6'd59;
  localparam logic [MIN_W-1:0]   LAST_MINUTE     = 6'd59;
  localparam logic [HOUR_W-1:0]  LAST_HOUR       = 5'd23;
  localparam logic [HOUR_W-1:0]  HALF_DAY_HOURS  = 5'd12;
  localparam logic [WDAY_W-1:0]  LAST_WEEKDAY    = 3'd6;
  localparam logic [MONTH_W-1:0] LAST_MONTH      = 4'd11;
  localparam logic [DAY_W-1:0]   FIRST_DAY       = 5'd1;

  // Display format code carried with every result.
  typedef enum logic [FMT_W-1:0] {
    FMT_AM  = 2'd0,
    FMT_PM  = 2'd1,
    FMT_24H = 2'd2
  } fmt_code_t;

  // Configuration register indexes.
  typedef enum logic {
    REG_TICKS_PER_SECOND = 1'b0,
    REG_UNUSED           = 1'b1
  } reg_index_t;

  // One result item, first field in the highest bits once packed.
  typedef struct packed {
    logic [MONTH_W-1:0] month_out;
    logic [DAY_W-1:0]   day_out;
    logic [WDAY_W-1:0]  weekday_out;
    fmt_code_t          format_code;
    logic [HOUR_W-1:0]  hours_shown;
    logic [MIN_W-1:0]   minutes_out;
    logic [SEC_W-1:0]   seconds_out;
  } result_t;

  // Days in each month, no leap years.
  function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] month);
    logic [DAY_W-1:0] len;
    unique case (month)
      4'd1:                      len = 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== src/clock_calendar_counter_top.sv =====
// ----------------------------------------------------------------------------
// clock_calendar_counter_top
// Millisecond-tick driven time of day and calendar with a 12/24-hour display.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  --------  ---------  ------------------------------------------------------
//  s_*       in         one tick: button_level in s_tdata[0]
//  m_*       out        one result: seconds, minutes, hours, format, weekday,
//                       day and month packed into m_tdata[30:0]
//  APB       in/out     ticks_per_second at byte address 0
//
//  A tick may be accepted in every cycle while the result output is not stalled.
//  The calendar state and the result register are written at the same edge,
//  so a result appears on m_tdata the cycle after its tick transfer.
//  The single result register sets the rate: s_tready is high whenever that
//  register is empty or is being taken in the same cycle.
//  Reset (rst, synchronous) restores 00:00:00, Monday, January 1, 24-hour
//  mode, and a period of 1000 ticks per second.
//
module clock_calendar_counter_top
  import clk_cal_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Tick stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [0] button_level, [7:1] zero
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,     // [5:0] seconds_out, [11:6] minutes_out,
                                   // [16:12] hours_shown, [18:17] format_code,
                                   // [21:19] weekday_out, [26:22] day_out,
                                   // [30:27] month_out, [31] zero
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Configuration register.
  logic [TICK_W-1:0]  ticks_per_second;

  // Clock and calendar state.
  logic [TICK_W-1:0]  tick_count;
  logic [SEC_W-1:0]   second_count;
  logic [MIN_W-1:0]   minute_count;
  logic [HOUR_W-1:0]  hour_count;
  logic               twelve_hour_flag;
  logic               button_prev;
  logic [WDAY_W-1:0]  weekday_count;
  logic [DAY_W-1:0]   day_count;
  logic [MONTH_W-1:0] month_count;

  logic [TICK_W-1:0]  tick_count_next;
  logic [SEC_W-1:0]   second_count_next;
  logic [MIN_W-1:0]   minute_count_next;
  logic [HOUR_W-1:0]  hour_count_next;
  logic               twelve_hour_flag_next;
  logic [WDAY_W-1:0]  weekday_count_next;
  logic [DAY_W-1:0]   day_count_next;
  logic [MONTH_W-1:0] month_count_next;

  logic [TICK_W-1:0]  tick_inc;
  logic               sec_step;
  logic               min_step;
  logic               hour_step;
  logic               day_step;
  logic               month_step;
  logic               button;

  result_t            result_next;
  result_t            result;
  logic               out_valid;

  logic               in_xfer;
  logic               cfg_write;
  reg_index_t         cfg_index;

  // --------------------------------------------------------------------------
  // Handshakes. The result register frees up when it is empty or when its
  // current contents leave in this cycle.
  // --------------------------------------------------------------------------
  assign s_tready = !out_valid || m_tready;
  assign in_xfer  = s_tvalid && s_tready;
  assign button   = s_tdata[0];

  // --------------------------------------------------------------------------
  // APB port. Only bit 2 of the address selects a register; the low bits are
  // the byte offset within a word.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_index = reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (cfg_index == REG_TICKS_PER_SECOND) begin
      prdata = {16'd0, ticks_per_second};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TICKS_RESET;
    end else if (cfg_write && cfg_index == REG_TICKS_PER_SECOND) begin
      ticks_per_second <= pwdata[TICK_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Counter cascade. The prescaler wraps when it reaches the period; a period
  // of zero therefore advances one second on every tick. Each stage carries
  // into the next only when it wraps, and the month only when the day passes
  // the length of the current month.
  // --------------------------------------------------------------------------
  always_comb begin
    tick_inc  = tick_count + 16'd1;
    sec_step  = (tick_inc >= ticks_per_second);
    min_step  = sec_step && (second_count == LAST_SECOND);
    hour_step = min_step && (minute_count == LAST_MINUTE);
    day_step  = hour_step && (hour_count == LAST_HOUR);
    month_step = day_step && (day_count >= month_length(month_count));

    tick_count_next   = sec_step ? '0 : tick_inc;

    second_count_next = second_count;
    if (sec_step) begin
      second_count_next = (second_count == LAST_SECOND) ? '0 : second_count + 6'd1;
    end

    minute_count_next = minute_count;
    if (min_step) begin
      minute_count_next = (minute_count == LAST_MINUTE) ? '0 : minute_count + 6'd1;
    end

    hour_count_next = hour_count;
    if (hour_step) begin
      hour_count_next = (hour_count == LAST_HOUR) ? '0 : hour_count + 5'd1;
    end

    weekday_count_next = weekday_count;
    day_count_next     = day_count;
    if (day_step) begin
      weekday_count_next = (weekday_count >= LAST_WEEKDAY) ? '0 : weekday_count + 3'd1;
      day_count_next     = month_step ? FIRST_DAY : day_count + 5'd1;
    end

    month_count_next = month_count;
    if (month_step) begin
      month_count_next = (month_count >= LAST_MONTH) ? '0 : month_count + 4'd1;
    end

    // A rising button edge flips the format, visible in this tick's result.
    twelve_hour_flag_next = twelve_hour_flag ^ (button && !button_prev);
  end

  // --------------------------------------------------------------------------
  // Result built from the updated state. Twelve-hour mode folds the afternoon
  // hours down by twelve, so noon and midnight both show zero.
  // --------------------------------------------------------------------------
  always_comb begin
    result_next.seconds_out = second_count_next;
    result_next.minutes_out = minute_count_next;
    result_next.weekday_out = weekday_count_next;
    result_next.day_out     = day_count_next;
    result_next.month_out   = month_count_next;
    if (twelve_hour_flag_next) begin
      if (hour_count_next < HALF_DAY_HOURS) begin
        result_next.hours_shown = hour_count_next;
        result_next.format_code = FMT_AM;
      end else begin
        result_next.hours_shown = hour_count_next - HALF_DAY_HOURS;
        result_next.format_code = FMT_PM;
      end
    end else begin
      result_next.hours_shown = hour_count_next;
      result_next.format_code = FMT_24H;
    end
  end

  // State registers advance only on a tick transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count       <= '0;
      second_count     <= '0;
      minute_count     <= '0;
      hour_count       <= '0;
      twelve_hour_flag <= 1'b0;
      button_prev      <= 1'b0;
      weekday_count    <= '0;
      day_count        <= FIRST_DAY;
      month_count      <= '0;
    end else if (in_xfer) begin
      tick_count       <= tick_count_next;
      second_count     <= second_count_next;
      minute_count     <= minute_count_next;
      hour_count       <= hour_count_next;
      twelve_hour_flag <= twelve_hour_flag_next;
      button_prev      <= button;
      weekday_count    <= weekday_count_next;
      day_count        <= day_count_next;
      month_count      <= month_count_next;
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      result <= result_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, result};

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_day_in_month: assert property (@(posedge clk) disable iff (rst)
    (day_count >= FIRST_DAY) && (day_count <= month_length(month_count)))
    else $error("day of month outside the current month");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    month_count <= LAST_MONTH)
    else $error("month index out of range");

  a_toggle_on_edge: assert property (@(posedge clk) disable iff (rst)
    in_xfer && button && !button_prev |=> twelve_hour_flag != $past(twelve_hour_flag))
    else $error("rising button edge did not toggle the hour format");

  a_twelve_hour_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (result.format_code == FMT_AM || result.format_code == FMT_PM)
      |-> result.hours_shown < HALF_DAY_HOURS)
    else $error("twelve-hour display shows an hour of twelve or more");

  a_result_follows_tick: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> out_valid && result.seconds_out == second_count)
    else $error("result does not match the updated seconds");

endmodule
